// ===== design/mphm_pkg.sv =====
`timescale 1ns / 1ps

package mphm_pkg;

	localparam int DATA_W = 32;
	localparam int TIME_W = 64;
	localparam int MASK_W = 4;
	localparam int FAIL_W = 3;
	localparam int INC_W  = 3;
	localparam int CFG_IDX_W = 3;

	localparam int BIT_GUEST   = 0;
	localparam int BIT_FREE    = 1;
	localparam int BIT_LARGEST = 2;
	localparam int BIT_FAILURE = 3;

	localparam int FR_QUOTA     = 0;
	localparam int FR_ALLOCATOR = 1;
	localparam int FR_NATIVE    = 2;

	localparam logic [DATA_W-1:0] DATA_MAX = {DATA_W{1'b1}};

	localparam logic [DATA_W-1:0] RST_GUEST_ENTER   = 32'd32768;
	localparam logic [DATA_W-1:0] RST_GUEST_EXIT    = 32'd49152;
	localparam logic [DATA_W-1:0] RST_FREE_ENTER    = 32'd24576;
	localparam logic [DATA_W-1:0] RST_FREE_EXIT     = 32'd36864;
	localparam logic [DATA_W-1:0] RST_LARGEST_ENTER = 32'd16384;
	localparam logic [DATA_W-1:0] RST_LARGEST_EXIT  = 32'd24576;
	localparam logic [DATA_W-1:0] RST_RECOVERY      = 32'd500000;

	typedef enum logic [1:0] {
		OP_SAMPLE,
		OP_VM_REPORT,
		OP_NATIVE_FAIL,
		OP_UNUSED
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GUEST_ENTER,
		CFG_GUEST_EXIT,
		CFG_FREE_ENTER,
		CFG_FREE_EXIT,
		CFG_LARGEST_ENTER,
		CFG_LARGEST_EXIT,
		CFG_RECOVERY
	} cfg_idx_t;

	// Running view of the mask while one item's updates are applied in order.
	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [MASK_W-1:0] eflags;
		logic [INC_W-1:0]  incs;
	} mphm_chain_t;

	function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b);
		logic [DATA_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[DATA_W] ? DATA_MAX : sum[DATA_W-1:0];
	endfunction

	// One mask update; a change from no flags to some flags opens an episode.
	function automatic mphm_chain_t mphm_apply(input mphm_chain_t s,
		input logic [MASK_W-1:0] m);
		mphm_chain_t r;
		r = s;
		if (m != s.mask) begin
			if (s.mask == '0) begin
				r.incs   = s.incs + INC_W'(1);
				r.eflags = '0;
			end
			r.mask   = m;
			r.eflags = r.eflags | m;
		end
		return r;
	endfunction

endpackage

// ===== design/memory_pressure_hysteresis_monitor_core.sv =====
`timescale 1ns / 1ps

// Memory-pressure hysteresis monitor.
// Input channel (in_valid/in_ready) carries one item: a sample, a VM failure
// report or a native allocation failure event, each stamped with now_us.
// Output channel (out_valid/out_ready) returns exactly one result item per
// input item, showing the pressure mask, episode data and failure totals as
// they stand after that item.
// An accepted item is held in an input register and evaluated when
// no result is waiting or out_ready is high; then the state and the result
// register load together. One item per cycle holds while out_ready is high.
// The result outputs are the state registers themselves plus mask_changed,
// so a result stays on the ports until the next item is evaluated.
// When the receiver stalls, the waiting input item stays in its register and
// in_ready drops; nothing is lost and acceptance resumes with out_ready.
// The user writes threshold registers via cfg_we/cfg_index/cfg_data while
// the block is idle (not enforced); an index beyond the list is ignored.
// Reset clears all flags, counters and healthy markers, loads the default
// thresholds and leaves both channels empty.
module memory_pressure_hysteresis_monitor_core import mphm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           operation,
	input  logic [TIME_W-1:0]    now_us,
	input  logic [DATA_W-1:0]    heap_used,
	input  logic [DATA_W-1:0]    heap_limit,
	input  logic                 sizes_valid,
	input  logic [DATA_W-1:0]    free_size,
	input  logic [DATA_W-1:0]    largest_block,
	input  logic [DATA_W-1:0]    quota_cnt,
	input  logic [DATA_W-1:0]    alloc_cnt,
	input  logic [DATA_W-1:0]    failure_count,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [MASK_W-1:0]    pressure_mask,
	output logic [DATA_W-1:0]    episode_number,
	output logic [MASK_W-1:0]    episode_causes,
	output logic [FAIL_W-1:0]    fail_causes,
	output logic [DATA_W-1:0]    quota_failures,
	output logic [DATA_W-1:0]    alloc_fail_total,
	output logic [DATA_W-1:0]    native_fail_total,
	output logic                 mask_changed,
	output logic [DATA_W-1:0]    guest_headroom
);

	// Configuration registers.
	logic [DATA_W-1:0] guest_enter_q, guest_exit_q;
	logic [DATA_W-1:0] free_enter_q, free_exit_q;
	logic [DATA_W-1:0] largest_enter_q, largest_exit_q;
	logic [DATA_W-1:0] recovery_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guest_enter_q   <= RST_GUEST_ENTER;
			guest_exit_q    <= RST_GUEST_EXIT;
			free_enter_q    <= RST_FREE_ENTER;
			free_exit_q     <= RST_FREE_EXIT;
			largest_enter_q <= RST_LARGEST_ENTER;
			largest_exit_q  <= RST_LARGEST_EXIT;
			recovery_q      <= RST_RECOVERY;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GUEST_ENTER:   guest_enter_q   <= cfg_data;
				CFG_GUEST_EXIT:    guest_exit_q    <= cfg_data;
				CFG_FREE_ENTER:    free_enter_q    <= cfg_data;
				CFG_FREE_EXIT:     free_exit_q     <= cfg_data;
				CFG_LARGEST_ENTER: largest_enter_q <= cfg_data;
				CFG_LARGEST_EXIT:  largest_exit_q  <= cfg_data;
				CFG_RECOVERY:      recovery_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage. Guest headroom is worked out on the way in so that the
	// evaluation cycle only has to compare it.
	logic              valid_s1;
	op_t               op_s1;
	logic [TIME_W-1:0] now_s1;
	logic [DATA_W-1:0] headroom_s1;
	logic              limit_nz_s1;
	logic              nvalid_s1;
	logic [DATA_W-1:0] free_s1, largest_s1, quota_s1, alloc_s1;
	logic              fcount_nz_s1;
	logic [DATA_W-1:0] headroom_in;
	logic              advance;
	logic              out_valid_q;

	assign headroom_in = (heap_limit > heap_used) ? (heap_limit - heap_used) : '0;
	assign advance     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready    = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1        <= op_t'(operation);
			now_s1       <= now_us;
			headroom_s1  <= headroom_in;
			limit_nz_s1  <= heap_limit != '0;
			nvalid_s1    <= sizes_valid;
			free_s1      <= free_size;
			largest_s1   <= largest_block;
			quota_s1     <= quota_cnt;
			alloc_s1     <= alloc_cnt;
			fcount_nz_s1 <= failure_count != '0;
		end
	end

	// Monitor state; it doubles as the result register.
	logic [MASK_W-1:0] mask_q, eflags_q;
	logic [DATA_W-1:0] episode_q;
	logic [FAIL_W-1:0] fflags_q;
	logic [TIME_W-1:0] last_fail_q;
	logic [DATA_W-1:0] quota_q, alloc_q, native_q, pending_q, headroom_q;
	logic              changed_q;

	logic is_sample, is_report, pend_nz;
	logic guest_en, native_en;
	logic guest_bit, free_bit, largest_bit;

	assign is_sample = op_s1 == OP_SAMPLE;
	assign is_report = (op_s1 == OP_VM_REPORT) && fcount_nz_s1;
	assign pend_nz   = pending_q != '0;
	assign guest_en  = is_sample && limit_nz_s1;
	assign native_en = is_sample && nvalid_s1;

	mphm_level u_guest (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (advance && guest_en),
		.value  (headroom_s1),
		.enter  (guest_enter_q),
		.leave  (guest_exit_q),
		.now    (now_s1),
		.rec    (recovery_q),
		.flag   (mask_q[BIT_GUEST]),
		.flag_n (guest_bit)
	);

	mphm_level u_free (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (advance && native_en),
		.value  (free_s1),
		.enter  (free_enter_q),
		.leave  (free_exit_q),
		.now    (now_s1),
		.rec    (recovery_q),
		.flag   (mask_q[BIT_FREE]),
		.flag_n (free_bit)
	);

	mphm_level u_largest (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (advance && native_en),
		.value  (largest_s1),
		.enter  (largest_enter_q),
		.leave  (largest_exit_q),
		.now    (now_s1),
		.rec    (recovery_q),
		.flag   (mask_q[BIT_LARGEST]),
		.flag_n (largest_bit)
	);

	// Failure flag recovery. When pending native failures are consumed by
	// this sample the last failure time becomes now, so no time has passed.
	logic [TIME_W-1:0] fail_diff;
	logic              fail_ok;

	assign fail_diff = now_s1 - last_fail_q;
	assign fail_ok   = pend_nz ? (recovery_q == '0)
	                           : (fail_diff >= {{(TIME_W-DATA_W){1'b0}}, recovery_q});

	// The mask updates of one item are applied in the same order as the
	// checks, each one able to open an episode of its own.
	mphm_chain_t c0, c1, c2, c3, c4, c5, c_fin;
	logic [MASK_W-1:0] m_tmp;

	always_comb begin
		c0.mask   = mask_q;
		c0.eflags = eflags_q;
		c0.incs   = '0;
		m_tmp     = mask_q | MASK_W'(1 << BIT_FAILURE);
		c1 = (is_sample && pend_nz) ? mphm_apply(c0, m_tmp) : c0;
		m_tmp = c1.mask;
		m_tmp[BIT_GUEST] = guest_bit;
		c2 = guest_en ? mphm_apply(c1, m_tmp) : c1;
		m_tmp = c2.mask;
		m_tmp[BIT_FREE] = free_bit;
		c3 = native_en ? mphm_apply(c2, m_tmp) : c2;
		m_tmp = c3.mask;
		m_tmp[BIT_LARGEST] = largest_bit;
		c4 = native_en ? mphm_apply(c3, m_tmp) : c3;
		m_tmp = c4.mask;
		m_tmp[BIT_FAILURE] = 1'b0;
		c5 = (c4.mask[BIT_FAILURE] && fail_ok) ? mphm_apply(c4, m_tmp) : c4;
		m_tmp = mask_q | MASK_W'(1 << BIT_FAILURE);
		if (is_sample) begin
			c_fin = c5;
		end else if (is_report) begin
			c_fin = mphm_apply(c0, m_tmp);
		end else begin
			c_fin = c0;
		end
	end

	logic [DATA_W:0]   episode_sum;
	logic [DATA_W-1:0] episode_n;

	assign episode_sum = {1'b0, episode_q} + (DATA_W+1)'(c_fin.incs);
	assign episode_n   = episode_sum[DATA_W] ? DATA_MAX : episode_sum[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			eflags_q    <= '0;
			episode_q   <= '0;
			fflags_q    <= '0;
			last_fail_q <= '0;
			quota_q     <= '0;
			alloc_q     <= '0;
			native_q    <= '0;
			pending_q   <= '0;
			headroom_q  <= '0;
			changed_q   <= 1'b0;
		end else if (advance) begin
			mask_q    <= c_fin.mask;
			eflags_q  <= c_fin.eflags;
			episode_q <= episode_n;
			changed_q <= c_fin.mask != mask_q;
			case (op_s1)
				OP_SAMPLE: begin
					headroom_q <= headroom_s1;
					if (pend_nz) begin
						native_q              <= sat_add(native_q, pending_q);
						pending_q             <= '0;
						fflags_q[FR_NATIVE]   <= 1'b1;
						last_fail_q           <= now_s1;
					end
				end
				OP_VM_REPORT: begin
					if (fcount_nz_s1) begin
						quota_q     <= sat_add(quota_q, quota_s1);
						alloc_q     <= sat_add(alloc_q, alloc_s1);
						last_fail_q <= now_s1;
						if (quota_s1 != '0) begin
							fflags_q[FR_QUOTA] <= 1'b1;
						end
						if (alloc_s1 != '0) begin
							fflags_q[FR_ALLOCATOR] <= 1'b1;
						end
					end
				end
				OP_NATIVE_FAIL: begin
					pending_q <= sat_add(pending_q, DATA_W'(1));
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid         = out_valid_q;
	assign pressure_mask     = mask_q;
	assign episode_number    = episode_q;
	assign episode_causes    = eflags_q;
	assign fail_causes       = fflags_q;
	assign quota_failures    = quota_q;
	assign alloc_fail_total  = alloc_q;
	assign native_fail_total = native_q;
	assign mask_changed      = changed_q;
	assign guest_headroom    = headroom_q;

	// Every evaluated item leaves a result behind.
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("evaluated item produced no result");

	// An accepted item always reaches the input stage.
	a_accept_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted item missing from input stage");

	// The episode number saturates and never goes back.
	a_episode_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> episode_q >= $past(episode_q))
		else $error("episode number decreased");

	// Every active flag has been recorded as a reason of the current episode.
	a_reasons_cover: assert property (@(posedge clk) disable iff (!arst_n)
		(mask_q & ~eflags_q) == '0)
		else $error("active flag missing from episode reasons");

endmodule

// ===== design/mphm_level.sv =====
`timescale 1ns / 1ps

module mphm_level import mphm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd,
	input  logic [DATA_W-1:0] value,
	input  logic [DATA_W-1:0] enter,
	input  logic [DATA_W-1:0] leave,
	input  logic [TIME_W-1:0] now,
	input  logic [DATA_W-1:0] rec,
	input  logic              flag,
	output logic              flag_n
);

	logic              hvalid_q;
	logic [TIME_W-1:0] hstart_q;
	logic              hvalid_n;
	logic              load_start;
	logic              below;
	logic              healthy;
	logic              elapsed;
	logic [TIME_W-1:0] diff;

	assign below   = value < enter;
	assign healthy = value >= leave;
	assign diff    = now - hstart_q;
	// A fresh healthy start is this sample's time, so zero time has passed.
	assign elapsed = hvalid_q ? (diff >= {{(TIME_W-DATA_W){1'b0}}, rec}) : (rec == '0);

	always_comb begin
		flag_n     = flag;
		hvalid_n   = hvalid_q;
		load_start = 1'b0;
		if (below) begin
			hvalid_n = 1'b0;
			flag_n   = 1'b1;
		end else if (flag) begin
			if (healthy) begin
				if (!hvalid_q) begin
					hvalid_n   = 1'b1;
					load_start = 1'b1;
				end
				if (elapsed) begin
					flag_n = 1'b0;
				end
			end else begin
				hvalid_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q <= 1'b0;
		end else if (upd) begin
			hvalid_q <= hvalid_n;
		end
	end

	always_ff @(posedge clk) begin
		if (upd && load_start) begin
			hstart_q <= now;
		end
	end

endmodule
